[hdl/i2cm_pkg.sv]
`default_nettype none
package i2cm_pkg;

  localparam int MAX_BYTES = 8;
  localparam int CNT_W = $clog2(MAX_BYTES + 2);
  localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_LOAD     = 2'd1,
    ACT_START_WR = 2'd2,
    ACT_START_RD = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_START = 2'd2
  } cmd_kind_e;

  typedef enum logic [1:0] {
    CFG_SHORT_HOLD = 2'd0,
    CFG_LONG_HOLD  = 2'd1,
    CFG_DEV_ADDR   = 2'd2
  } cfg_index_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic             is_read;
    logic [7:0]       wbyte;
    logic [CNT_W-1:0] len;
    logic             sda;
  } cmd_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [7:0] read_data;
    logic       read_valid;
    logic       busy;
    logic       done;
    logic       ack_missing;
  } res_t;

endpackage
`default_nettype wire

[hdl/i2cm_front.sv]
`default_nettype none
module i2cm_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire logic [1:0]    action_i,
  input  wire logic [7:0]    write_byte_i,
  input  wire logic [3:0]    byte_count_i,
  input  wire logic          sda_in_i,
  output logic               cmd_valid_o,
  output i2cm_pkg::cmd_t     cmd_o,
  input  wire logic          cmd_take_i
);
  import i2cm_pkg::*;

  cmd_t       cmd_new;
  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       wr_en, rd_en;

  always_comb begin
    cmd_new.wbyte   = write_byte_i;
    cmd_new.sda     = sda_in_i;
    cmd_new.is_read = 1'b0;
    cmd_new.kind    = CMD_TICK;
    if (32'(byte_count_i) > 32'(MAX_BYTES)) begin
      cmd_new.len = CNT_W'(MAX_BYTES);
    end else begin
      cmd_new.len = CNT_W'(byte_count_i);
    end
    case (action_e'(action_i))
      ACT_TICK:     cmd_new.kind = CMD_TICK;
      ACT_LOAD:     cmd_new.kind = CMD_LOAD;
      ACT_START_WR: cmd_new.kind = CMD_START;
      ACT_START_RD: begin
        cmd_new.kind    = CMD_START;
        cmd_new.is_read = 1'b1;
      end
      default:      cmd_new.kind = CMD_TICK;
    endcase
  end

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rd_ptr_q];
  assign wr_en       = push && !full;
  assign rd_en       = cmd_take_i && cmd_valid_o;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (rd_en) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/i2cm_back.sv]
`default_nettype none
module i2cm_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_index_i,
  input  wire logic [7:0]    cfg_data_i,
  input  wire logic          cmd_valid_i,
  input  wire i2cm_pkg::cmd_t cmd_i,
  output logic               cmd_take_o,
  input  wire logic          res_full_i,
  output logic               res_push_o,
  output i2cm_pkg::res_t     res_o
);
  import i2cm_pkg::*;

  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_ST1       = 4'd1;
  localparam logic [3:0] PH_ST2       = 4'd2;
  localparam logic [3:0] PH_ST3       = 4'd3;
  localparam logic [3:0] PH_ST4       = 4'd4;
  localparam logic [3:0] PH_BIT_LOW   = 4'd5;
  localparam logic [3:0] PH_BIT_DATA  = 4'd6;
  localparam logic [3:0] PH_BIT_HIGH  = 4'd7;
  localparam logic [3:0] PH_ACK_LOW   = 4'd8;
  localparam logic [3:0] PH_ACK_DATA  = 4'd9;
  localparam logic [3:0] PH_ACK_HIGH  = 4'd10;
  localparam logic [3:0] PH_STOP_LOW  = 4'd11;
  localparam logic [3:0] PH_STOP_HIGH = 4'd12;

  function automatic logic [7:0] hold_of(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  logic [7:0]       short_hold_q, long_hold_q, dev_addr_q;
  logic [3:0]       phase_q, phase_d;
  logic [7:0]       hold_q, hold_d;
  logic [3:0]       bit_q, bit_d;
  logic [CNT_W-1:0] byte_idx_q, byte_idx_d;
  logic [7:0]       shift_q, shift_d;
  logic [7:0]       wbuf_q [MAX_BYTES];
  logic [7:0]       wbuf_rd_q;
  logic [CNT_W-1:0] load_ptr_q, load_ptr_d;
  logic             nack_q, nack_d;
  logic             scl_q, scl_d;
  logic             sda_q, sda_d;
  logic             is_read_q, is_read_d;
  logic [CNT_W-1:0] txn_len_q, txn_len_d;

  logic             wb_we;
  logic [CNT_W-1:0] next_idx, begin_idx;
  logic [7:0]       begin_shift;
  logic             receiving;
  logic [7:0]       shifted;
  logic [3:0]       bit_inc;
  logic [7:0]       rdata;
  logic             rvalid, done;

  assign cmd_take_o = cmd_valid_i && !res_full_i;
  assign res_push_o = cmd_take_o;

  assign receiving = is_read_q && (byte_idx_q != '0);
  assign next_idx  = byte_idx_q + CNT_W'(1);
  assign begin_idx = (phase_q == PH_ST4) ? byte_idx_q : next_idx;
  assign shifted   = {shift_q[6:0], receiving ? cmd_i.sda : 1'b0};
  assign bit_inc   = bit_q + 4'd1;

  // The next write byte sits at the current byte index; its read register
  // settles long before the acknowledge phase that loads it.
  always_comb begin
    if (begin_idx == '0) begin
      begin_shift = dev_addr_q + {7'd0, is_read_q};
    end else if (is_read_q) begin
      begin_shift = 8'd0;
    end else begin
      begin_shift = wbuf_rd_q;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    hold_d     = hold_q;
    bit_d      = bit_q;
    byte_idx_d = byte_idx_q;
    shift_d    = shift_q;
    load_ptr_d = load_ptr_q;
    nack_d     = nack_q;
    scl_d      = scl_q;
    sda_d      = sda_q;
    is_read_d  = is_read_q;
    txn_len_d  = txn_len_q;
    wb_we      = 1'b0;
    rdata      = 8'd0;
    rvalid     = 1'b0;
    done       = 1'b0;
    if (phase_q == PH_IDLE) begin
      if (cmd_i.kind == CMD_LOAD) begin
        if (load_ptr_q < CNT_W'(MAX_BYTES)) begin
          wb_we      = 1'b1;
          load_ptr_d = load_ptr_q + CNT_W'(1);
        end
      end else if (cmd_i.kind == CMD_START) begin
        is_read_d  = cmd_i.is_read;
        txn_len_d  = cmd_i.len;
        load_ptr_d = '0;
        nack_d     = 1'b0;
        byte_idx_d = '0;
        bit_d      = 4'd0;
        sda_d      = 1'b1;
        phase_d    = PH_ST1;
        hold_d     = hold_of(short_hold_q);
      end
    end else if (hold_q > 8'd1) begin
      hold_d = hold_q - 8'd1;
    end else begin
      case (phase_q)
        PH_ST1: begin
          scl_d   = 1'b1;
          phase_d = PH_ST2;
          hold_d  = hold_of(long_hold_q);
        end
        PH_ST2: begin
          sda_d   = 1'b0;
          phase_d = PH_ST3;
          hold_d  = hold_of(long_hold_q);
        end
        PH_ST3: begin
          scl_d   = 1'b0;
          phase_d = PH_ST4;
          hold_d  = hold_of(long_hold_q);
        end
        PH_ST4: begin
          shift_d = begin_shift;
          bit_d   = 4'd0;
          scl_d   = 1'b0;
          phase_d = PH_BIT_LOW;
          hold_d  = hold_of(short_hold_q);
        end
        PH_BIT_LOW: begin
          sda_d   = receiving ? 1'b1 : shift_q[7];
          phase_d = PH_BIT_DATA;
          hold_d  = hold_of(short_hold_q);
        end
        PH_BIT_DATA: begin
          scl_d   = 1'b1;
          phase_d = PH_BIT_HIGH;
          hold_d  = hold_of(short_hold_q);
        end
        PH_BIT_HIGH: begin
          shift_d = shifted;
          bit_d   = bit_inc;
          scl_d   = 1'b0;
          hold_d  = hold_of(short_hold_q);
          if (bit_inc >= 4'd8) begin
            if (receiving) begin
              rdata  = shifted;
              rvalid = 1'b1;
            end
            phase_d = PH_ACK_LOW;
          end else begin
            phase_d = PH_BIT_LOW;
          end
        end
        PH_ACK_LOW: begin
          if (receiving) begin
            sda_d = (byte_idx_q >= txn_len_q);
          end else begin
            sda_d = 1'b1;
          end
          phase_d = PH_ACK_DATA;
          hold_d  = hold_of(short_hold_q);
        end
        PH_ACK_DATA: begin
          scl_d   = 1'b1;
          phase_d = PH_ACK_HIGH;
          hold_d  = hold_of(short_hold_q);
        end
        PH_ACK_HIGH: begin
          if (!receiving && cmd_i.sda) begin
            nack_d = 1'b1;
          end
          byte_idx_d = next_idx;
          hold_d     = hold_of(short_hold_q);
          scl_d      = 1'b0;
          if (next_idx > txn_len_q) begin
            sda_d   = 1'b0;
            phase_d = PH_STOP_LOW;
          end else begin
            shift_d = begin_shift;
            bit_d   = 4'd0;
            phase_d = PH_BIT_LOW;
          end
        end
        PH_STOP_LOW: begin
          scl_d   = 1'b1;
          phase_d = PH_STOP_HIGH;
          hold_d  = hold_of(long_hold_q);
        end
        PH_STOP_HIGH: begin
          sda_d   = 1'b1;
          phase_d = PH_IDLE;
          hold_d  = 8'd0;
          done    = 1'b1;
        end
        default: begin
          phase_d = PH_IDLE;
          hold_d  = 8'd0;
          scl_d   = 1'b1;
          sda_d   = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    res_o.scl         = scl_d;
    res_o.sda         = sda_d;
    res_o.read_data   = rdata;
    res_o.read_valid  = rvalid;
    res_o.busy        = (phase_d != PH_IDLE);
    res_o.done        = done;
    res_o.ack_missing = nack_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o && wb_we) begin
      wbuf_q[load_ptr_q[IDX_W-1:0]] <= cmd_i.wbyte;
    end
    wbuf_rd_q <= wbuf_q[byte_idx_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_hold_q <= 8'd2;
      long_hold_q  <= 8'd5;
      dev_addr_q   <= 8'd192;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_SHORT_HOLD: short_hold_q <= cfg_data_i;
        CFG_LONG_HOLD:  long_hold_q  <= cfg_data_i;
        CFG_DEV_ADDR:   dev_addr_q   <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      hold_q     <= 8'd0;
      bit_q      <= 4'd0;
      byte_idx_q <= '0;
      shift_q    <= 8'd0;
      load_ptr_q <= '0;
      nack_q     <= 1'b0;
      scl_q      <= 1'b1;
      sda_q      <= 1'b1;
      is_read_q  <= 1'b0;
      txn_len_q  <= '0;
    end else if (cmd_take_o) begin
      phase_q    <= phase_d;
      hold_q     <= hold_d;
      bit_q      <= bit_d;
      byte_idx_q <= byte_idx_d;
      shift_q    <= shift_d;
      load_ptr_q <= load_ptr_d;
      nack_q     <= nack_d;
      scl_q      <= scl_d;
      sda_q      <= sda_d;
      is_read_q  <= is_read_d;
      txn_len_q  <= txn_len_d;
    end
  end

endmodule
`default_nettype wire

[hdl/i2cm_resq.sv]
`default_nettype none
module i2cm_resq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          res_push_i,
  input  wire i2cm_pkg::res_t res_i,
  output logic               res_full_o,
  output logic               empty,
  input  wire logic          pop,
  output i2cm_pkg::res_t     res_o
);
  import i2cm_pkg::*;

  res_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       wr_en, rd_en;

  assign res_full_o = (cnt_q == 2'd2);
  assign empty      = (cnt_q == 2'd0);
  assign res_o      = mem_q[rd_ptr_q];
  assign wr_en      = res_push_i && !res_full_o;
  assign rd_en      = pop && !empty;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (rd_en) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/i2c_bitbang_transaction_master_core.sv]
// An accepted item is registered in the command queue and its result in the result queue,
// whose head drives the result ports; the sequencer logic between them is combinational.
// Throughput: one item per cycle; the pin sequencer retires one item per cycle
// whenever the two-entry command queue holds one and the result queue has room.
// Reset is asynchronous and active low: queues empty, sequencer idle, both
// lines released high, hold registers at 2 and 5, device address 0xC0.
`default_nettype none
module i2c_bitbang_transaction_master_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] action_i,
  input  wire logic [7:0] write_byte_i,
  input  wire logic [3:0] byte_count_i,
  input  wire logic       sda_in_i,
  output logic            empty,
  input  wire logic       pop,
  output logic            scl_level_o,
  output logic            sda_level_o,
  output logic [7:0]      read_data_o,
  output logic            read_valid_o,
  output logic            busy_res_o,
  output logic            done_res_o,
  output logic            ack_missing_o
);
  import i2cm_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_take;
  res_t res_new, res_head;
  logic res_push, res_full;

  i2cm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .action_i     (action_i),
    .write_byte_i (write_byte_i),
    .byte_count_i (byte_count_i),
    .sda_in_i     (sda_in_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_take_i   (cmd_take)
  );

  i2cm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_new)
  );

  i2cm_resq u_resq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .res_i      (res_new),
    .res_full_o (res_full),
    .empty      (empty),
    .pop        (pop),
    .res_o      (res_head)
  );

  assign scl_level_o   = res_head.scl;
  assign sda_level_o   = res_head.sda;
  assign read_data_o   = res_head.read_data;
  assign read_valid_o  = res_head.read_valid;
  assign busy_res_o    = res_head.busy;
  assign done_res_o    = res_head.done;
  assign ack_missing_o = res_head.ack_missing;

endmodule
`default_nettype wire

[sim/tb_top.sv]
module tb_top;
  import i2cm_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 8000000;

  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_START_A,
    SEQ_START_B,
    SEQ_START_C,
    SEQ_START_D,
    SEQ_BIT_LOW,
    SEQ_BIT_DATA,
    SEQ_BIT_HIGH,
    SEQ_ACK_LOW,
    SEQ_ACK_DATA,
    SEQ_ACK_HIGH,
    SEQ_STOP_LOW,
    SEQ_STOP_HIGH
  } seq_phase_e;

  class i2c_txn_scoreboard;
    logic [7:0] short_hold;
    logic [7:0] long_hold;
    logic [7:0] dev_addr;
    seq_phase_e phase_q;
    logic [7:0] hold_left;
    logic [3:0] bit_num;
    logic [3:0] byte_num;
    logic [3:0] txn_len;
    logic [7:0] shifter;
    logic [7:0] wr_buf [MAX_BYTES];
    int unsigned load_ptr;
    int unsigned stored_hi;
    logic nack_q;
    logic scl_q;
    logic sda_q;
    logic rd_mode;
    res_t expected_q[$];
    int unsigned errors;
    int unsigned results_seen;
    int unsigned wr_txns;
    int unsigned rd_txns;
    int unsigned bytes_read;
    int unsigned nack_txns;

    function new();
      short_hold = 8'd2;
      long_hold = 8'd5;
      dev_addr = 8'hC0;
      phase_q = SEQ_IDLE;
      hold_left = '0;
      bit_num = '0;
      byte_num = '0;
      txn_len = '0;
      shifter = '0;
      load_ptr = 0;
      stored_hi = 0;
      nack_q = 1'b0;
      scl_q = 1'b1;
      sda_q = 1'b1;
      rd_mode = 1'b0;
      errors = 0;
      results_seen = 0;
      wr_txns = 0;
      rd_txns = 0;
      bytes_read = 0;
      nack_txns = 0;
    endfunction

    function bit busy();
      return phase_q != SEQ_IDLE;
    endfunction

    function bit receiving();
      return rd_mode && byte_num != 4'd0;
    endfunction

    function void enter(seq_phase_e ph, bit long_phase);
      logic [7:0] v;
      v = long_phase ? long_hold : short_hold;
      phase_q = ph;
      hold_left = (v == 8'd0) ? 8'd1 : v;
    endfunction

    function void begin_byte();
      if (byte_num == 4'd0) begin
        shifter = dev_addr + {7'd0, rd_mode};
      end else if (rd_mode) begin
        shifter = 8'd0;
      end else begin
        shifter = wr_buf[byte_num - 4'd1];
      end
      bit_num = 4'd0;
      scl_q = 1'b0;
      enter(SEQ_BIT_LOW, 1'b0);
    endfunction

    function void write_reg(cfg_index_e idx, logic [7:0] v);
      case (idx)
        CFG_SHORT_HOLD: short_hold = v;
        CFG_LONG_HOLD: long_hold = v;
        CFG_DEV_ADDR: dev_addr = v;
        default: ;
      endcase
    endfunction

    function void note_item(action_e act, logic [7:0] wb, logic [3:0] cnt, logic sda);
      res_t r;
      r = '0;
      if (phase_q == SEQ_IDLE) begin
        if (act == ACT_LOAD) begin
          if (load_ptr < MAX_BYTES) begin
            wr_buf[load_ptr] = wb;
            load_ptr++;
            if (load_ptr > stored_hi) stored_hi = load_ptr;
          end
        end else if (act == ACT_START_WR || act == ACT_START_RD) begin
          rd_mode = (act == ACT_START_RD);
          txn_len = (cnt > MAX_BYTES) ? 4'(MAX_BYTES) : cnt;
          load_ptr = 0;
          nack_q = 1'b0;
          byte_num = 4'd0;
          bit_num = 4'd0;
          sda_q = 1'b1;
          if (rd_mode) rd_txns++;
          else wr_txns++;
          enter(SEQ_START_A, 1'b0);
        end
      end else if (hold_left > 8'd1) begin
        hold_left--;
      end else begin
        case (phase_q)
          SEQ_START_A: begin
            scl_q = 1'b1;
            enter(SEQ_START_B, 1'b1);
          end
          SEQ_START_B: begin
            sda_q = 1'b0;
            enter(SEQ_START_C, 1'b1);
          end
          SEQ_START_C: begin
            scl_q = 1'b0;
            enter(SEQ_START_D, 1'b1);
          end
          SEQ_START_D: begin_byte();
          SEQ_BIT_LOW: begin
            sda_q = receiving() ? 1'b1 : shifter[7];
            enter(SEQ_BIT_DATA, 1'b0);
          end
          SEQ_BIT_DATA: begin
            scl_q = 1'b1;
            enter(SEQ_BIT_HIGH, 1'b0);
          end
          SEQ_BIT_HIGH: begin
            shifter = {shifter[6:0], receiving() ? sda : 1'b0};
            bit_num++;
            scl_q = 1'b0;
            if (bit_num >= 4'd8) begin
              if (receiving()) begin
                r.read_data = shifter;
                r.read_valid = 1'b1;
                bytes_read++;
              end
              enter(SEQ_ACK_LOW, 1'b0);
            end else begin
              enter(SEQ_BIT_LOW, 1'b0);
            end
          end
          SEQ_ACK_LOW: begin
            sda_q = receiving() ? (byte_num >= txn_len) : 1'b1;
            enter(SEQ_ACK_DATA, 1'b0);
          end
          SEQ_ACK_DATA: begin
            scl_q = 1'b1;
            enter(SEQ_ACK_HIGH, 1'b0);
          end
          SEQ_ACK_HIGH: begin
            if (!receiving() && sda) nack_q = 1'b1;
            byte_num++;
            if (byte_num > txn_len) begin
              scl_q = 1'b0;
              sda_q = 1'b0;
              enter(SEQ_STOP_LOW, 1'b0);
            end else begin
              begin_byte();
            end
          end
          SEQ_STOP_LOW: begin
            scl_q = 1'b1;
            enter(SEQ_STOP_HIGH, 1'b1);
          end
          SEQ_STOP_HIGH: begin
            sda_q = 1'b1;
            phase_q = SEQ_IDLE;
            hold_left = 8'd0;
            r.done = 1'b1;
            if (nack_q) nack_txns++;
          end
          default: begin
            phase_q = SEQ_IDLE;
            hold_left = 8'd0;
            scl_q = 1'b1;
            sda_q = 1'b1;
          end
        endcase
      end
      r.scl = scl_q;
      r.sda = sda_q;
      r.busy = (phase_q != SEQ_IDLE);
      r.ack_missing = nack_q;
      expected_q.push_back(r);
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none actual %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      results_seen++;
      check_field("scl_level", 8'(want.scl), 8'(got.scl));
      check_field("sda_level", 8'(want.sda), 8'(got.sda));
      check_field("read_data", want.read_data, got.read_data);
      check_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
      check_field("busy_res", 8'(want.busy), 8'(got.busy));
      check_field("done_res", 8'(want.done), 8'(got.done));
      check_field("ack_missing", 8'(want.ack_missing), 8'(got.ack_missing));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  cfg_index_e cfg_index_i = CFG_SHORT_HOLD;
  logic [7:0] cfg_data_i = 8'd0;
  logic push = 1'b0;
  logic full;
  action_e action_i = ACT_TICK;
  logic [7:0] write_byte_i = 8'd0;
  logic [3:0] byte_count_i = 4'd0;
  logic sda_in_i = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic scl_level_o;
  logic sda_level_o;
  logic [7:0] read_data_o;
  logic read_valid_o;
  logic busy_res_o;
  logic done_res_o;
  logic ack_missing_o;
  res_t dut_res;

  i2c_txn_scoreboard sb = new();
  bit idling_on = 1'b1;
  int stall_left = 0;
  int unsigned cycles = 0;
  int unsigned sent_items = 0;

  i2c_bitbang_transaction_master_core u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .push(push),
    .full(full),
    .action_i(action_i),
    .write_byte_i(write_byte_i),
    .byte_count_i(byte_count_i),
    .sda_in_i(sda_in_i),
    .empty(empty),
    .pop(pop),
    .scl_level_o(scl_level_o),
    .sda_level_o(sda_level_o),
    .read_data_o(read_data_o),
    .read_valid_o(read_valid_o),
    .busy_res_o(busy_res_o),
    .done_res_o(done_res_o),
    .ack_missing_o(ack_missing_o)
  );

  assign dut_res = {scl_level_o, sda_level_o, read_data_o, read_valid_o,
                    busy_res_o, done_res_o, ack_missing_o};

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("i2c_bitbang_transaction_master_core: mismatch");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk_i) begin
    if (pop && !empty) sb.check_result(dut_res);
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else if (idling_on && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap() - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic send_item(action_e act, logic [7:0] wb, logic [3:0] cnt, logic sda);
    int gap;
    action_i <= act;
    write_byte_i <= wb;
    byte_count_i <= cnt;
    sda_in_i <= sda;
    push <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_item(act, wb, cnt, sda);
    sent_items++;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = pick_gap();
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    if (push) push <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // sda_mode: 0 holds the data line low, 1 holds it high, 2 randomizes it.
  task automatic finish_txn(int sda_mode);
    logic sda;
    while (sb.busy()) begin
      sda = (sda_mode == 2) ? ($urandom_range(0, 3) == 0) : sda_mode[0];
      send_item(ACT_TICK, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)), sda);
    end
  endtask

  task automatic set_config(logic [7:0] short_v, logic [7:0] long_v, logic [7:0] addr_v);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_SHORT_HOLD;
    cfg_data_i <= short_v;
    @(posedge clk_i);
    cfg_index_i <= CFG_LONG_HOLD;
    cfg_data_i <= long_v;
    @(posedge clk_i);
    cfg_index_i <= CFG_DEV_ADDR;
    cfg_data_i <= addr_v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(CFG_SHORT_HOLD, short_v);
    sb.write_reg(CFG_LONG_HOLD, long_v);
    sb.write_reg(CFG_DEV_ADDR, addr_v);
  endtask

  // Sends random items until the running total of sent items reaches the target.
  task automatic run_random(int unsigned target);
    int r;
    action_e act;
    logic [7:0] wb;
    logic [3:0] cnt;
    logic sda;
    while (sent_items < target) begin
      wb = 8'($urandom_range(0, 255));
      cnt = 4'($urandom_range(0, 15));
      sda = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (sb.busy()) begin
        act = (r < 4) ? action_e'($urandom_range(0, 3)) : ACT_TICK;
      end else if (r < 6) begin
        act = ACT_TICK;
      end else if (r < 45) begin
        act = ACT_LOAD;
      end else if (r < 72) begin
        act = ACT_START_WR;
        if (sb.stored_hi == MAX_BYTES && r < 52) cnt = 4'($urandom_range(0, 15));
        else cnt = 4'($urandom_range(0, sb.stored_hi));
      end else begin
        act = ACT_START_RD;
        if (r < 94) cnt = 4'($urandom_range(0, 3));
      end
      send_item(act, wb, cnt, sda);
      if (sent_items % 100 == 0) idling_on = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 299) == 0) drain();
    end
  endtask

  task automatic run_phase(logic [7:0] short_v, logic [7:0] long_v, logic [7:0] addr_v,
                           int unsigned target);
    finish_txn(2);
    drain();
    set_config(short_v, long_v, addr_v);
    run_random(target);
  endtask

  initial begin
    logic [7:0] load_bytes [9];
    load_bytes = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hA5, 8'h5A, 8'h7F, 8'hFE, 8'h3C};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(ACT_TICK, 8'h00, 4'd0, 1'b0);
    send_item(ACT_START_RD, 8'h00, 4'd1, 1'b0);
    send_item(ACT_START_WR, 8'hFF, 4'd15, 1'b1);
    send_item(ACT_LOAD, 8'h99, 4'd0, 1'b1);
    finish_txn(2);
    drain();
    set_config(8'd1, 8'd1, 8'hFF);

    foreach (load_bytes[i]) send_item(ACT_LOAD, load_bytes[i], 4'd0, 1'b0);
    send_item(ACT_START_WR, 8'hFF, 4'd15, 1'b1);
    send_item(ACT_START_RD, 8'h00, 4'd3, 1'b1);
    send_item(ACT_LOAD, 8'h99, 4'd0, 1'b1);
    finish_txn(1);
    send_item(ACT_START_WR, 8'h00, 4'd0, 1'b0);
    finish_txn(0);
    send_item(ACT_START_RD, 8'h00, 4'd2, 1'b0);
    finish_txn(1);
    send_item(ACT_START_RD, 8'h00, 4'd0, 1'b0);
    finish_txn(2);

    run_phase(8'd1, 8'd1, 8'h00, 800);
    run_phase(8'd0, 8'd0, 8'hA4, 1050);
    idling_on = 1'b0;
    run_phase(8'd2, 8'd3, 8'h3C, 1250);
    idling_on = 1'b1;
    run_phase(8'd1, 8'd4, 8'($urandom_range(0, 254)), 1450);

    finish_txn(2);
    drain();
    $display("Checked %0d results over %0d write and %0d read transactions, %0d bytes received.",
             sb.results_seen, sb.wr_txns, sb.rd_txns, sb.bytes_read);
    $display("%0d transactions flagged a missing acknowledge; holds of zero, one and several ticks ran.",
             sb.nack_txns);
    if (sb.errors == 0) begin
      $display("i2c_bitbang_transaction_master_core: match");
    end else begin
      $display("i2c_bitbang_transaction_master_core: mismatch");
    end
    $finish;
  end

endmodule
